>>> rtl/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, character codes and the control program of the Roman
// numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  // ascii codes of the numeral letters
  localparam logic [6:0] CH_I    = 7'h49;
  localparam logic [6:0] CH_V    = 7'h56;
  localparam logic [6:0] CH_X    = 7'h58;
  localparam logic [6:0] CH_L    = 7'h4C;
  localparam logic [6:0] CH_C    = 7'h43;
  localparam logic [6:0] CH_D    = 7'h44;
  localparam logic [6:0] CH_M    = 7'h4D;
  localparam logic [6:0] CH_NONE = 7'h00;

  // largest value that has a numeral
  localparam logic [11:0] MAX_VALUE = 12'd3999;

  // decimal places
  typedef logic [1:0] place_t;
  localparam place_t PLACE_ONES      = 2'd0;
  localparam place_t PLACE_TENS      = 2'd1;
  localparam place_t PLACE_HUNDREDS  = 2'd2;
  localparam place_t PLACE_THOUSANDS = 2'd3;

  // which symbol of a place
  typedef enum logic [1:0] {
    KIND_ONE,
    KIND_FIVE,
    KIND_TEN
  } kind_e;

  // micro operations
  typedef enum logic [2:0] {
    OP_SPLIT100,
    OP_SPLIT10,
    OP_THOU,
    OP_HEAD,
    OP_TAIL,
    OP_END,
    OP_ERR
  } op_e;

  typedef logic [3:0] uaddr_t;

  // one control word
  typedef struct packed {
    op_e    op;
    place_t place;
    uaddr_t jump;
  } ucode_t;

  // entry points of the program
  localparam uaddr_t UA_START = 4'd0;
  localparam uaddr_t UA_ERR   = 4'd10;

  // controls of the decimal digit datapath
  typedef struct packed {
    logic load;
    logic split100;
    logic split10;
    logic dec_th;
  } bcd_ctrl_t;

  // control program: split digits, thousands, then head and tail of each place
  function automatic ucode_t ucode_rom(uaddr_t addr);
    ucode_t w;
    case (addr)
      4'd0:    w = '{op: OP_SPLIT100, place: PLACE_HUNDREDS,  jump: 4'd1};
      4'd1:    w = '{op: OP_SPLIT10,  place: PLACE_TENS,      jump: 4'd2};
      4'd2:    w = '{op: OP_THOU,     place: PLACE_THOUSANDS, jump: 4'd3};
      4'd3:    w = '{op: OP_HEAD,     place: PLACE_HUNDREDS,  jump: 4'd5};
      4'd4:    w = '{op: OP_TAIL,     place: PLACE_HUNDREDS,  jump: 4'd5};
      4'd5:    w = '{op: OP_HEAD,     place: PLACE_TENS,      jump: 4'd7};
      4'd6:    w = '{op: OP_TAIL,     place: PLACE_TENS,      jump: 4'd7};
      4'd7:    w = '{op: OP_HEAD,     place: PLACE_ONES,      jump: 4'd9};
      4'd8:    w = '{op: OP_TAIL,     place: PLACE_ONES,      jump: 4'd9};
      4'd9:    w = '{op: OP_END,      place: PLACE_ONES,      jump: UA_START};
      4'd10:   w = '{op: OP_ERR,      place: PLACE_ONES,      jump: UA_START};
      default: w = '{op: OP_END,      place: PLACE_ONES,      jump: UA_START};
    endcase
    return w;
  endfunction

  // letter for a symbol kind at a place
  function automatic logic [6:0] sym_for(kind_e kind, place_t place);
    logic [6:0] s;
    s = CH_M;
    case (place)
      PLACE_ONES: begin
        case (kind)
          KIND_ONE:  s = CH_I;
          KIND_FIVE: s = CH_V;
          default:   s = CH_X;
        endcase
      end
      PLACE_TENS: begin
        case (kind)
          KIND_ONE:  s = CH_X;
          KIND_FIVE: s = CH_L;
          default:   s = CH_C;
        endcase
      end
      PLACE_HUNDREDS: begin
        case (kind)
          KIND_ONE:  s = CH_C;
          KIND_FIVE: s = CH_D;
          default:   s = CH_M;
        endcase
      end
      default: s = CH_M;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/rne_bcd.sv
// ----------------------------------------------------------------------------
// rne_bcd
// Binary to decimal digit split: thousands on load, then hundreds, then
// tens and ones, one step per control pulse.
// ----------------------------------------------------------------------------
module rne_bcd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rne_pkg::bcd_ctrl_t ctrl_i,
  input  logic [11:0]       number_i,
  output logic [1:0]        th_o,
  output logic [3:0]        hu_o,
  output logic [3:0]        te_o,
  output logic [3:0]        on_o
);
  import rne_pkg::*;

  logic [1:0]  th_q, th_d;
  logic [3:0]  hu_q, hu_d;
  logic [3:0]  te_q, te_d;
  logic [3:0]  on_q, on_d;
  logic [9:0]  rem_q, rem_d;

  logic [1:0]  th_load;
  logic [11:0] th_value;
  logic [15:0] prod100;
  logic [3:0]  hu_new;
  logic [9:0]  hu_x100;
  logic [14:0] prod10;
  logic [3:0]  te_new;
  logic [6:0]  te_x10;

  // thousands by compare
  always_comb begin
    if (number_i >= 12'd3000) begin
      th_load  = 2'd3;
      th_value = 12'd3000;
    end else if (number_i >= 12'd2000) begin
      th_load  = 2'd2;
      th_value = 12'd2000;
    end else if (number_i >= 12'd1000) begin
      th_load  = 2'd1;
      th_value = 12'd1000;
    end else begin
      th_load  = 2'd0;
      th_value = 12'd0;
    end
  end

  // hundreds by reciprocal multiply, exact below 1000
  assign prod100 = 16'(rem_q) * 16'd41;
  assign hu_new  = prod100[15:12];
  assign hu_x100 = 10'(hu_new) * 10'd100;

  // tens by reciprocal multiply, exact below 100
  assign prod10 = 15'(rem_q[6:0]) * 15'd205;
  assign te_new = prod10[14:11];
  assign te_x10 = 7'(te_new) * 7'd10;

  // next digit values
  always_comb begin
    th_d  = th_q;
    hu_d  = hu_q;
    te_d  = te_q;
    on_d  = on_q;
    rem_d = rem_q;
    if (ctrl_i.load) begin
      th_d  = th_load;
      rem_d = 10'(number_i - th_value);
    end
    if (ctrl_i.dec_th) begin
      th_d = th_q - 2'd1;
    end
    if (ctrl_i.split100) begin
      hu_d  = hu_new;
      rem_d = rem_q - hu_x100;
    end
    if (ctrl_i.split10) begin
      te_d = te_new;
      on_d = 4'(rem_q[6:0] - te_x10);
    end
  end

  // digit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_q  <= '0;
      hu_q  <= '0;
      te_q  <= '0;
      on_q  <= '0;
      rem_q <= '0;
    end else begin
      th_q  <= th_d;
      hu_q  <= hu_d;
      te_q  <= te_d;
      on_q  <= on_d;
      rem_q <= rem_d;
    end
  end

  assign th_o = th_q;
  assign hu_o = hu_q;
  assign te_o = te_q;
  assign on_o = on_q;

endmodule

>>> rtl/roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Converts a 12-bit number into its subtractive Roman numeral, one ASCII
// letter per strobe, most significant first.
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low. Letters come out one
// per cycle, with gaps at split steps and steps that give no letter, on
// symbol_o with strobe_o high for exactly one cycle each; the receiver cannot
// stall them, so it must take every strobe. last_o marks the final letter.
// Inputs of 0 or above 3999 give a single strobe with symbol 0, last 1 and
// error 1. After the transfer of a valid number the block splits it into
// decimal digits in a hundreds step and a tens step, then takes a step per
// letter, a step when there are no thousands and a step for each zero
// hundreds or tens digit that still has letters after it; zero digits after
// the final letter take no step. The microcode sequencer steps once per
// cycle and holds busy until the final letter is made. Each letter appears
// in the cycle after the step that makes it.
module roman_numeral_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [11:0] number_i,
  output logic        busy,
  output logic        strobe_o,
  output logic [6:0]  symbol_o,
  output logic        last_o,
  output logic        error_o
);
  import rne_pkg::*;

  logic        active_q, active_d;
  uaddr_t      upc_q, upc_d;
  logic [1:0]  cnt_q, cnt_d;
  kind_e       kind_q, kind_d;
  logic        strobe_q;
  logic [6:0]  symbol_q;
  logic        last_q;
  logic        error_q;

  logic        accept;
  logic        num_err;
  ucode_t      uw;
  bcd_ctrl_t   bcd_ctrl;
  logic [1:0]  th;
  logic [3:0]  hu;
  logic [3:0]  te;
  logic [3:0]  on;
  logic [3:0]  digit;
  logic        lower_zero;
  logic        emit;
  logic [6:0]  sym;
  logic        lst;
  logic        err;
  kind_e       head_kind;
  logic [3:0]  digit_m5;

  assign accept  = start && !busy;
  assign num_err = (number_i == 12'd0) || (number_i > MAX_VALUE);
  assign uw      = ucode_rom(upc_q);
  assign digit_m5 = digit - 4'd5;

  // decimal digits
  rne_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (bcd_ctrl),
    .number_i (number_i),
    .th_o     (th),
    .hu_o     (hu),
    .te_o     (te),
    .on_o     (on)
  );

  // digit of the current place and whether lower places add letters
  always_comb begin
    case (uw.place)
      PLACE_HUNDREDS: begin
        digit      = hu;
        lower_zero = (te == 4'd0) && (on == 4'd0);
      end
      PLACE_TENS: begin
        digit      = te;
        lower_zero = (on == 4'd0);
      end
      PLACE_ONES: begin
        digit      = on;
        lower_zero = 1'b1;
      end
      default: begin
        digit      = 4'd0;
        lower_zero = (hu == 4'd0) && (te == 4'd0) && (on == 4'd0);
      end
    endcase
  end

  // sequencer: execute the current control word
  always_comb begin
    active_d  = active_q;
    upc_d     = upc_q;
    cnt_d     = cnt_q;
    kind_d    = kind_q;
    bcd_ctrl  = '0;
    emit      = 1'b0;
    sym       = CH_NONE;
    lst       = 1'b0;
    err       = 1'b0;
    head_kind = KIND_ONE;
    if (accept) begin
      active_d      = 1'b1;
      upc_d         = num_err ? UA_ERR : UA_START;
      bcd_ctrl.load = 1'b1;
    end else if (active_q) begin
      case (uw.op)
        OP_SPLIT100: begin
          bcd_ctrl.split100 = 1'b1;
          upc_d             = uw.jump;
        end
        OP_SPLIT10: begin
          bcd_ctrl.split10 = 1'b1;
          upc_d            = uw.jump;
        end
        OP_THOU: begin
          if (th != 2'd0) begin
            emit            = 1'b1;
            sym             = CH_M;
            bcd_ctrl.dec_th = 1'b1;
            lst             = (th == 2'd1) && lower_zero;
            upc_d           = (th > 2'd1) ? upc_q : uw.jump;
          end else begin
            upc_d = uw.jump;
          end
        end
        OP_HEAD: begin
          // first letter of the digit and what remains after it
          case (digit)
            4'd1, 4'd2, 4'd3: begin
              emit      = 1'b1;
              head_kind = KIND_ONE;
              kind_d    = KIND_ONE;
              cnt_d     = digit[1:0] - 2'd1;
            end
            4'd4: begin
              emit      = 1'b1;
              head_kind = KIND_ONE;
              kind_d    = KIND_FIVE;
              cnt_d     = 2'd1;
            end
            4'd5, 4'd6, 4'd7, 4'd8: begin
              emit      = 1'b1;
              head_kind = KIND_FIVE;
              kind_d    = KIND_ONE;
              cnt_d     = digit_m5[1:0];
            end
            4'd9: begin
              emit      = 1'b1;
              head_kind = KIND_ONE;
              kind_d    = KIND_TEN;
              cnt_d     = 2'd1;
            end
            default: begin
              cnt_d = 2'd0;
            end
          endcase
          sym   = sym_for(head_kind, uw.place);
          lst   = emit && (cnt_d == 2'd0) && lower_zero;
          upc_d = (emit && (cnt_d != 2'd0)) ? upc_q + 4'd1 : uw.jump;
        end
        OP_TAIL: begin
          emit  = 1'b1;
          sym   = sym_for(kind_q, uw.place);
          cnt_d = cnt_q - 2'd1;
          lst   = (cnt_q == 2'd1) && lower_zero;
          upc_d = (cnt_q == 2'd1) ? uw.jump : upc_q;
        end
        OP_ERR: begin
          emit = 1'b1;
          sym  = CH_NONE;
          lst  = 1'b1;
          err  = 1'b1;
        end
        OP_END: begin
          active_d = 1'b0;
        end
        default: begin
          active_d = 1'b0;
        end
      endcase
      if (emit && lst) begin
        active_d = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      upc_q    <= UA_START;
      cnt_q    <= 2'd0;
      kind_q   <= KIND_ONE;
      strobe_q <= 1'b0;
    end else begin
      active_q <= active_d;
      upc_q    <= upc_d;
      cnt_q    <= cnt_d;
      kind_q   <= kind_d;
      strobe_q <= emit;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    symbol_q <= sym;
    last_q   <= lst;
    error_q  <= err;
  end

  assign busy     = active_q;
  assign strobe_o = strobe_q;
  assign symbol_o = symbol_q;
  assign last_o   = last_q;
  assign error_o  = error_q;

  // an error result is a lone zero symbol
  a_err_lone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && error_o) |-> (last_o && (symbol_o == CH_NONE)))
    else $error("error result without last or with nonzero symbol");

  // a transfer starts the sequencer
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after a transfer");

  // the final letter is not followed at once by another
  a_last_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |=> !strobe_o)
    else $error("strobe right after the final letter");

  // letters come only from a running sequence
  a_strobe_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("strobe without a running sequence");

  // tail steps only run with letters left in the digit
  a_tail_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && (uw.op == OP_TAIL)) |-> (cnt_q != 2'd0))
    else $error("tail step with no letters left");

endmodule

>>> dv/tb_roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// tb_roman_numeral_encoder
// Self-checking bench for the Roman numeral encoder. A directed table covers
// the range ends, out-of-range values and every digit pattern, then random
// numbers follow with random sender idling. Every letter strobe is checked
// against a predictor of the subtractive numeral.
// ----------------------------------------------------------------------------
module tb_roman_numeral_encoder;
  import rne_pkg::*;

  // one output letter as seen on the result ports
  typedef struct packed {
    logic [6:0] symbol;
    logic       last;
    logic       error;
  } letter_t;

  // one row of the directed table, with an optional typed-in single letter
  typedef struct packed {
    logic [11:0] value;
    logic        typed;
    logic [6:0]  symbol;
    logic        last;
    logic        error;
  } numeral_row_t;

  localparam int unsigned RandomCount = 236;
  localparam int unsigned SteadyCount = 40;
  localparam int unsigned DrainCycles = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [11:0] number_i = '0;
  logic        busy;
  logic        strobe_o;
  logic [6:0]  symbol_o;
  logic        last_o;
  logic        error_o;

  letter_t     expected_letters [$];
  int unsigned mismatch_count = 0;

  numeral_row_t directed_rows [24] = '{
    '{12'd0,    1'b1, CH_NONE, 1'b1, 1'b1},
    '{12'd4095, 1'b1, CH_NONE, 1'b1, 1'b1},
    '{12'd4000, 1'b1, CH_NONE, 1'b1, 1'b1},
    '{12'd1,    1'b1, CH_I,    1'b1, 1'b0},
    '{12'd5,    1'b1, CH_V,    1'b1, 1'b0},
    '{12'd10,   1'b1, CH_X,    1'b1, 1'b0},
    '{12'd50,   1'b1, CH_L,    1'b1, 1'b0},
    '{12'd100,  1'b1, CH_C,    1'b1, 1'b0},
    '{12'd500,  1'b1, CH_D,    1'b1, 1'b0},
    '{12'd1000, 1'b1, CH_M,    1'b1, 1'b0},
    '{12'd3999, 1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd3888, 1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd4,    1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd9,    1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd40,   1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd90,   1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd400,  1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd900,  1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd3,    1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd1994, 1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd2048, 1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd1365, 1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd2730, 1'b0, CH_NONE, 1'b0, 1'b0},
    '{12'd3000, 1'b0, CH_NONE, 1'b0, 1'b0}
  };

  roman_numeral_encoder u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .number_i (number_i),
    .busy     (busy),
    .strobe_o (strobe_o),
    .symbol_o (symbol_o),
    .last_o   (last_o),
    .error_o  (error_o)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // count a failure, report only the first few
  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  // expected letters of the subtractive numeral for one number
  task automatic predict_numeral(input logic [11:0] value);
    logic [6:0]  chars [$];
    logic [6:0]  one_l [3];
    logic [6:0]  five_l [3];
    logic [6:0]  ten_l [3];
    int unsigned scale [3];
    int unsigned digit;
    letter_t     item;
    one_l  = '{CH_C, CH_X, CH_I};
    five_l = '{CH_D, CH_L, CH_V};
    ten_l  = '{CH_M, CH_C, CH_X};
    scale  = '{100, 10, 1};
    // out of range gives a single error letter
    if (value == 12'd0 || value > MAX_VALUE) begin
      item = '{symbol: CH_NONE, last: 1'b1, error: 1'b1};
      expected_letters.push_back(item);
      return;
    end
    repeat (value / 1000) chars.push_back(CH_M);
    // hundreds, tens, ones
    for (int p = 0; p < 3; p++) begin
      digit = (value / scale[p]) % 10;
      if (digit == 9) begin
        chars.push_back(one_l[p]);
        chars.push_back(ten_l[p]);
      end else if (digit == 4) begin
        chars.push_back(one_l[p]);
        chars.push_back(five_l[p]);
      end else if (digit >= 5) begin
        chars.push_back(five_l[p]);
        repeat (digit - 5) chars.push_back(one_l[p]);
      end else begin
        repeat (digit) chars.push_back(one_l[p]);
      end
    end
    foreach (chars[i]) begin
      item = '{symbol: chars[i], last: (i == chars.size() - 1), error: 1'b0};
      expected_letters.push_back(item);
    end
  endtask

  // hold start until the number transfer happens
  task automatic send_number(input logic [11:0] value);
    start    <= 1'b1;
    number_i <= value;
    do @(posedge clk_i); while (busy);
  endtask

  // drop start for a random burst
  task automatic idle_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // wait until every expected letter has come
  task automatic drain_letters();
    start <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk_i);
  endtask

  // random number: mostly valid, some long numerals, some out of range
  function automatic logic [11:0] pick_number();
    int unsigned heavy [4];
    heavy = '{3, 7, 8, 8};
    case ($urandom_range(0, 19))
      0:       return 12'd0;
      1:       return 12'($urandom_range(4000, 4095));
      2, 3:    return 12'($urandom_range(0, 3) * 1000 + heavy[$urandom_range(0, 3)] * 100
                          + heavy[$urandom_range(0, 3)] * 10 + heavy[$urandom_range(0, 3)]);
      default: return 12'($urandom_range(1, 3999));
    endcase
  endfunction

  // letter checker
  always @(posedge clk_i) begin : check_letters
    letter_t want;
    if (rst_ni && strobe_o) begin
      if (expected_letters.size() == 0) begin
        note_failure($sformatf("unexpected letter symbol=%h last=%b error=%b",
                               symbol_o, last_o, error_o));
      end else begin
        want = expected_letters.pop_front();
        if (symbol_o !== want.symbol || last_o !== want.last || error_o !== want.error) begin
          note_failure($sformatf("symbol=%h/%h last=%b/%b error=%b/%b (got/exp)",
                                 symbol_o, want.symbol, last_o, want.last,
                                 error_o, want.error));
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [11:0] value;
    letter_t     typed_letter;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      send_number(directed_rows[i].value);
      if (directed_rows[i].typed) begin
        typed_letter = '{symbol: directed_rows[i].symbol, last: directed_rows[i].last,
                         error: directed_rows[i].error};
        expected_letters.push_back(typed_letter);
      end else begin
        predict_numeral(directed_rows[i].value);
      end
      if ($urandom_range(0, 2) == 0) begin
        idle_sender($urandom_range(1, 5));
      end
    end
    drain_letters();

    // random numbers, no idling in the last stretch
    for (int unsigned n = 0; n < RandomCount; n++) begin
      value = pick_number();
      send_number(value);
      predict_numeral(value);
      if (n == RandomCount / 2) begin
        drain_letters();
      end else if (n < RandomCount - SteadyCount && $urandom_range(0, 3) == 0) begin
        idle_sender($urandom_range(1, 5));
      end
    end

    // wait out the tail
    drain_letters();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_letters.size() != 0) begin
      note_failure($sformatf("%0d letters never came", expected_letters.size()));
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #200000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
